// ===== rtl/core/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// Shared codes and constants for the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int SYM_W   = 8;
  localparam int NSYM    = 256;
  localparam int RES_CAP = 16;

  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_KW_BYTE = 3'd1;
  localparam logic [2:0] KIND_KW_END  = 3'd2;
  localparam logic [2:0] KIND_BUILD   = 3'd3;
  localparam logic [2:0] KIND_TEXT    = 3'd4;

  localparam logic RES_MATCH = 1'b0;
  localparam logic RES_BUILD = 1'b1;

endpackage

// ===== rtl/core/multi_pattern_string_matcher_core.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_core
// Aho-Corasick matcher: trie load, breadth-first link build, text matching.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+-----------------
//  command  | start, busy, kind_i, symbol_i,            | beat when start
//           | text_first_i                              | and !busy
//  result   | result_valid_o, result_kind_o, ...        | one-cycle strobe
//
// Sequencing: each child-table or link lookup has an issue and a data state.
//   A keyword byte does one child lookup; a keyword end reads and writes the
//   output set, or is ignored. A text beat does one lookup plus a link read
//   and lookup per failure hop; a non-root state adds the output-set read and
//   a scan of all keywords per match reported. Build: a lookup per root
//   symbol, then per queued state a dequeue, a link read and a lookup per
//   symbol, with a link walk and output-set merge per child, then finish.
// Reset / clear: the child table is swept with busy high; a clear beat starts
//   the same sweep. Results can not be stalled; busy drops in the cycle of
//   the last result of a beat.
module multi_pattern_string_matcher_core import acm_pkg::*; #(
  parameter int MAX_STATES    = 256,
  parameter int MAX_KEYWORDS  = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  symbol_i,
  input  logic        text_first_i,
  output logic        result_valid_o,
  output logic        result_kind_o,
  output logic        build_status_o,
  output logic [15:0] match_start_o,
  output logic [3:0]  keyword_index_o,
  output logic        position_saturated_o,
  output logic        last_o
);

  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int KW = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
  localparam int PB = POSITION_BITS;
  localparam int LW = ((PB > SW) ? PB : SW) + 1;
  localparam int TA = SW + SYM_W;

  typedef enum logic [24:0] {
    S_IDLE     = 25'h0000001,
    S_KB_ISS   = 25'h0000002,
    S_KB_CHK   = 25'h0000004,
    S_KE_ISS   = 25'h0000008,
    S_KE_WR    = 25'h0000010,
    S_BR_ISS   = 25'h0000020,
    S_BR_CHK   = 25'h0000040,
    S_B_DEQ    = 25'h0000080,
    S_B_U_WT   = 25'h0000100,
    S_B_FU_WT  = 25'h0000200,
    S_B_C_ISS  = 25'h0000400,
    S_B_C_CHK  = 25'h0000800,
    S_B_W_ISS  = 25'h0001000,
    S_B_W_CHK  = 25'h0002000,
    S_B_F_WT   = 25'h0004000,
    S_B_OG_WT  = 25'h0008000,
    S_B_OV_WT  = 25'h0010000,
    S_B_NEXT   = 25'h0020000,
    S_B_DONE   = 25'h0040000,
    S_T_ISS    = 25'h0080000,
    S_T_CHK    = 25'h0100000,
    S_T_F_WT   = 25'h0200000,
    S_T_OS_WT  = 25'h0400000,
    S_T_SCAN   = 25'h0800000,
    S_T_EMIT   = 25'h1000000
  } state_e;

  typedef logic [MAX_KEYWORDS-1:0] kset_t;

  state_e fsm_q, fsm_d;

  // loader and automaton registers
  logic [SW:0]    sc_q, sc_d;
  logic [KW:0]    kc_q, kc_d;
  logic [SW-1:0]  load_q, load_d;
  logic [SW-1:0]  len_q, len_d;
  logic           drop_q, drop_d;
  logic           ovf_q, ovf_d;
  logic           built_q, built_d;
  logic [SW-1:0]  ms_q, ms_d;
  logic [PB-1:0]  pos_q, pos_d;
  logic [PB-1:0]  pcur_q, pcur_d;
  logic [SYM_W-1:0] sym_q, sym_d;

  // build walk registers
  logic [SYM_W-1:0] c_q, c_d;
  logic [SW:0]    head_q, head_d, tail_q, tail_d;
  logic [SW-1:0]  u_q, u_d, fu_q, fu_d, v_q, v_d, f_q, f_d, s_q, s_d;
  kset_t          og_q, og_d;

  // match report registers
  kset_t          pend_q, pend_d;
  logic [KW-1:0]  i_q, i_d, best_q, best_d;
  logic [SW-1:0]  blen_q, blen_d;
  logic           have_q, have_d;
  logic [3:0]     n_q, n_d;

  // result registers
  logic           rv_q, rv_d;
  logic           rk_q, rk_d, rbs_q, rbs_d, rsat_q, rsat_d, rlast_q, rlast_d;
  logic [15:0]    rst_q, rst_d;
  logic [3:0]     ridx_q, ridx_d;

  // memories
  logic [SW-1:0]  fail_mem [MAX_STATES];
  logic           fail_we;
  logic [SW-1:0]  fail_wa, fail_wd, fail_ra, fail_rd_q;
  kset_t          os_mem [MAX_STATES];
  logic           os_we;
  logic [SW-1:0]  os_wa, os_ra;
  kset_t          os_wd, os_rd_q;
  logic [SW-1:0]  q_mem [MAX_STATES];
  logic           q_we;
  logic [SW-1:0]  q_wa, q_wd, q_ra, q_rd_q;
  logic [SW-1:0]  kl_q [MAX_KEYWORDS];
  logic           kl_we;

  logic           t_clr, t_we, t_busy;
  logic [TA-1:0]  t_wa, t_ra;
  logic [SW-1:0]  t_wd, t_rd;

  // helpers
  logic           cand, last_w;
  kset_t          pnew;
  logic [LW-1:0]  p1, lext, startv;
  logic [LW+15:0] st_ext;
  logic [KW+3:0]  idx_ext;
  logic           accept;

  acm_trie #(.SW(SW)) u_trie (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (t_clr),
    .rd_addr_i(t_ra),
    .rd_data_o(t_rd),
    .wr_en_i  (t_we),
    .wr_addr_i(t_wa),
    .wr_data_i(t_wd),
    .busy_o   (t_busy)
  );

  assign busy   = (fsm_q != S_IDLE) || t_busy;
  assign accept = start && !busy;

  assign cand   = pend_q[i_q] && (!have_q || (kl_q[i_q] > blen_q));
  assign pnew   = pend_q & ~(kset_t'(1) << best_q);
  assign last_w = (n_q == 4'(RES_CAP - 1)) || (pnew == '0);
  // start = pos + 1 - len, floored at zero
  assign p1     = LW'(pcur_q) + LW'(1);
  assign lext   = LW'(blen_q);
  assign startv = (lext > p1) ? '0 : (p1 - lext);
  assign st_ext = {16'b0, startv};
  assign idx_ext = {4'b0, best_q};

  always_comb begin
    fsm_d = fsm_q;
    sc_d = sc_q; kc_d = kc_q; load_d = load_q; len_d = len_q; drop_d = drop_q;
    ovf_d = ovf_q; built_d = built_q; ms_d = ms_q; pos_d = pos_q; pcur_d = pcur_q;
    sym_d = sym_q; c_d = c_q; head_d = head_q; tail_d = tail_q;
    u_d = u_q; fu_d = fu_q; v_d = v_q; f_d = f_q; s_d = s_q; og_d = og_q;
    pend_d = pend_q; i_d = i_q; best_d = best_q; blen_d = blen_q;
    have_d = have_q; n_d = n_q;
    rv_d = 1'b0; rk_d = rk_q; rbs_d = rbs_q; rsat_d = rsat_q; rlast_d = rlast_q;
    rst_d = rst_q; ridx_d = ridx_q;
    fail_we = 1'b0; fail_wa = '0; fail_wd = '0; fail_ra = '0;
    os_we = 1'b0; os_wa = '0; os_wd = '0; os_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    kl_we = 1'b0;
    t_clr = 1'b0; t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;

    unique case (fsm_q)
      S_IDLE: begin
        if (accept) begin
          sym_d = symbol_i;
          case (kind_i)
            KIND_CLEAR: begin
              t_clr = 1'b1;
              sc_d = (SW+1)'(1); kc_d = '0; load_d = '0; len_d = '0;
              drop_d = 1'b0; ovf_d = 1'b0; built_d = 1'b0;
              ms_d = '0; pos_d = '0;
            end
            KIND_KW_BYTE: begin
              built_d = 1'b0;
              if (!drop_q) begin
                if (kc_q >= (KW+1)'(MAX_KEYWORDS)) begin
                  ovf_d  = 1'b1;
                  drop_d = 1'b1;
                end else begin
                  fsm_d = S_KB_ISS;
                end
              end
            end
            KIND_KW_END: begin
              built_d = 1'b0;
              if (!drop_q && len_q != '0 && kc_q < (KW+1)'(MAX_KEYWORDS)) begin
                fsm_d = S_KE_ISS;
              end else begin
                load_d = '0; len_d = '0; drop_d = 1'b0;
              end
            end
            KIND_BUILD: begin
              fail_we = 1'b1; fail_wa = '0; fail_wd = '0;
              c_d = '0; head_d = '0; tail_d = '0;
              fsm_d = S_BR_ISS;
            end
            KIND_TEXT: begin
              if (built_q) begin
                pcur_d = text_first_i ? '0 : pos_q;
                pos_d  = (pcur_d != '1) ? pcur_d + PB'(1) : pcur_d;
                s_d    = text_first_i ? '0 : ms_q;
                fsm_d  = S_T_ISS;
              end
            end
            default: ;
          endcase
        end
      end
      // ---- keyword load ----
      S_KB_ISS: begin
        t_ra  = {load_q, sym_q};
        fsm_d = S_KB_CHK;
      end
      S_KB_CHK: begin
        fsm_d = S_IDLE;
        if (t_rd != '0) begin
          load_d = t_rd;
          len_d  = len_q + SW'(1);
        end else if (sc_q >= (SW+1)'(MAX_STATES)) begin
          ovf_d  = 1'b1;
          drop_d = 1'b1;
        end else begin
          t_we = 1'b1; t_wa = {load_q, sym_q}; t_wd = sc_q[SW-1:0];
          fail_we = 1'b1; fail_wa = sc_q[SW-1:0]; fail_wd = '0;
          os_we = 1'b1; os_wa = sc_q[SW-1:0]; os_wd = '0;
          sc_d   = sc_q + (SW+1)'(1);
          load_d = sc_q[SW-1:0];
          len_d  = len_q + SW'(1);
        end
      end
      S_KE_ISS: begin
        os_ra = load_q;
        fsm_d = S_KE_WR;
      end
      S_KE_WR: begin
        os_we = 1'b1; os_wa = load_q;
        os_wd = os_rd_q | (kset_t'(1) << kc_q);
        kl_we = 1'b1;
        kc_d = kc_q + (KW+1)'(1);
        load_d = '0; len_d = '0; drop_d = 1'b0;
        fsm_d = S_IDLE;
      end
      // ---- build: root children ----
      S_BR_ISS: begin
        t_ra  = {SW'(0), c_q};
        fsm_d = S_BR_CHK;
      end
      S_BR_CHK: begin
        if (t_rd != '0) begin
          fail_we = 1'b1; fail_wa = t_rd; fail_wd = '0;
          q_we = 1'b1; q_wa = tail_q[SW-1:0]; q_wd = t_rd;
          tail_d = tail_q + (SW+1)'(1);
        end
        c_d   = c_q + 8'd1;
        fsm_d = (c_q == 8'hFF) ? S_B_DEQ : S_BR_ISS;
      end
      // ---- build: breadth-first walk ----
      S_B_DEQ: begin
        if (head_q == tail_q) begin
          fsm_d = S_B_DONE;
        end else begin
          q_ra   = head_q[SW-1:0];
          head_d = head_q + (SW+1)'(1);
          fsm_d  = S_B_U_WT;
        end
      end
      S_B_U_WT: begin
        u_d = q_rd_q;
        fail_ra = q_rd_q;
        c_d = '0;
        fsm_d = S_B_FU_WT;
      end
      S_B_FU_WT: begin
        fu_d  = fail_rd_q;
        fsm_d = S_B_C_ISS;
      end
      S_B_C_ISS: begin
        t_ra  = {u_q, c_q};
        fsm_d = S_B_C_CHK;
      end
      S_B_C_CHK: begin
        if (t_rd == '0) begin
          fsm_d = S_B_NEXT;
        end else begin
          v_d = t_rd;
          f_d = fu_q;
          fsm_d = S_B_W_ISS;
        end
      end
      S_B_W_ISS: begin
        t_ra  = {f_q, c_q};
        fsm_d = S_B_W_CHK;
      end
      S_B_W_CHK: begin
        if (t_rd != '0 || f_q == '0) begin
          // link target found; a self link falls back to root
          fail_we = 1'b1; fail_wa = v_q;
          fail_wd = (t_rd == v_q) ? '0 : t_rd;
          q_we = 1'b1; q_wa = tail_q[SW-1:0]; q_wd = v_q;
          tail_d = tail_q + (SW+1)'(1);
          if (t_rd == v_q || t_rd == '0) begin
            fsm_d = S_B_NEXT;
          end else begin
            os_ra = t_rd;
            fsm_d = S_B_OG_WT;
          end
        end else begin
          fail_ra = f_q;
          fsm_d = S_B_F_WT;
        end
      end
      S_B_F_WT: begin
        f_d   = fail_rd_q;
        fsm_d = S_B_W_ISS;
      end
      S_B_OG_WT: begin
        og_d  = os_rd_q;
        os_ra = v_q;
        fsm_d = S_B_OV_WT;
      end
      S_B_OV_WT: begin
        os_we = 1'b1; os_wa = v_q; os_wd = os_rd_q | og_q;
        fsm_d = S_B_NEXT;
      end
      S_B_NEXT: begin
        c_d   = c_q + 8'd1;
        fsm_d = (c_q == 8'hFF) ? S_B_DEQ : S_B_C_ISS;
      end
      S_B_DONE: begin
        built_d = 1'b1; ms_d = '0; pos_d = '0;
        rv_d = 1'b1; rk_d = RES_BUILD; rbs_d = ovf_q; rst_d = '0;
        ridx_d = '0; rsat_d = 1'b0; rlast_d = 1'b1;
        fsm_d = S_IDLE;
      end
      // ---- text ----
      S_T_ISS: begin
        t_ra  = {s_q, sym_q};
        fsm_d = S_T_CHK;
      end
      S_T_CHK: begin
        if (t_rd != '0 || s_q == '0) begin
          ms_d = t_rd;
          if (t_rd == '0) begin
            fsm_d = S_IDLE;
          end else begin
            os_ra = t_rd;
            fsm_d = S_T_OS_WT;
          end
        end else begin
          fail_ra = s_q;
          fsm_d = S_T_F_WT;
        end
      end
      S_T_F_WT: begin
        s_d   = fail_rd_q;
        fsm_d = S_T_ISS;
      end
      S_T_OS_WT: begin
        pend_d = os_rd_q;
        n_d = '0; i_d = '0; have_d = 1'b0;
        fsm_d = (os_rd_q == '0) ? S_IDLE : S_T_SCAN;
      end
      S_T_SCAN: begin
        if (cand) begin
          best_d = i_q;
          blen_d = kl_q[i_q];
          have_d = 1'b1;
        end
        i_d = i_q + KW'(1);
        if (i_q == KW'(MAX_KEYWORDS - 1)) fsm_d = S_T_EMIT;
      end
      S_T_EMIT: begin
        rv_d = 1'b1; rk_d = RES_MATCH; rbs_d = 1'b0;
        rst_d = st_ext[15:0]; ridx_d = idx_ext[3:0];
        rsat_d = (pcur_q == '1); rlast_d = last_w;
        pend_d = pnew;
        n_d = n_q + 4'd1;
        i_d = '0; have_d = 1'b0;
        fsm_d = last_w ? S_IDLE : S_T_SCAN;
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= S_IDLE;
      sc_q <= (SW+1)'(1); kc_q <= '0; load_q <= '0; len_q <= '0;
      drop_q <= 1'b0; ovf_q <= 1'b0; built_q <= 1'b0;
      ms_q <= '0; pos_q <= '0;
      head_q <= '0; tail_q <= '0; n_q <= '0; have_q <= 1'b0; i_q <= '0;
      rv_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      sc_q <= sc_d; kc_q <= kc_d; load_q <= load_d; len_q <= len_d;
      drop_q <= drop_d; ovf_q <= ovf_d; built_q <= built_d;
      ms_q <= ms_d; pos_q <= pos_d;
      head_q <= head_d; tail_q <= tail_d; n_q <= n_d; have_q <= have_d; i_q <= i_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pcur_q <= pcur_d; sym_q <= sym_d; c_q <= c_d;
    u_q <= u_d; fu_q <= fu_d; v_q <= v_d; f_q <= f_d; s_q <= s_d; og_q <= og_d;
    pend_q <= pend_d; best_q <= best_d; blen_q <= blen_d;
    rk_q <= rk_d; rbs_q <= rbs_d; rsat_q <= rsat_d; rlast_q <= rlast_d;
    rst_q <= rst_d; ridx_q <= ridx_d;
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd_q <= fail_mem[fail_ra];
    if (os_we) os_mem[os_wa] <= os_wd;
    os_rd_q <= os_mem[os_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[q_ra];
    if (kl_we) kl_q[kc_q[KW-1:0]] <= len_q;
  end

  assign result_valid_o       = rv_q;
  assign result_kind_o        = rk_q;
  assign build_status_o       = rbs_q;
  assign match_start_o        = rst_q;
  assign keyword_index_o      = ridx_q;
  assign position_saturated_o = rsat_q;
  assign last_o               = rlast_q;

endmodule

// ===== rtl/core/acm_trie.sv =====
// ----------------------------------------------------------------------------
// acm_trie
// Child table memory: one read, one write port, clearing sweep after reset and on clear.
// ----------------------------------------------------------------------------
module acm_trie import acm_pkg::*; #(
  parameter int SW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic [SW+SYM_W-1:0] rd_addr_i,
  output logic [SW-1:0]      rd_data_o,
  input  logic               wr_en_i,
  input  logic [SW+SYM_W-1:0] wr_addr_i,
  input  logic [SW-1:0]      wr_data_i,
  output logic               busy_o
);

  localparam int AW    = SW + SYM_W;
  localparam int DEPTH = 1 << AW;

  logic [SW-1:0] mem [DEPTH];
  logic          sweep_q, sweep_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] rd_q;

  always_comb begin
    sweep_d = sweep_q;
    cnt_d   = cnt_q;
    if (clr_i) begin
      sweep_d = 1'b1;
      cnt_d   = '0;
    end else if (sweep_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == '1) sweep_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem[cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign busy_o    = sweep_q;

endmodule

// ===== rtl/core/acm_checker.sv =====
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks for the matcher core, bound into the core module.
// ----------------------------------------------------------------------------
module acm_checker import acm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  kind_i,
  input logic        result_valid_o,
  input logic        result_kind_o,
  input logic [15:0] match_start_o,
  input logic [3:0]  keyword_index_o,
  input logic        last_o
);

  a_build_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == RES_BUILD |-> last_o)
    else $error("build status not marked last");

  a_build_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == RES_BUILD |->
      match_start_o == 16'd0 && keyword_index_o == 4'd0)
    else $error("build status carries match fields");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("idle before last result of a beat");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KIND_CLEAR || kind_i == KIND_BUILD) |=> busy)
    else $error("clear or build beat did not raise busy");

endmodule

bind multi_pattern_string_matcher_core acm_checker u_acm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .match_start_o  (match_start_o),
  .keyword_index_o(keyword_index_o),
  .last_o         (last_o)
);
